// ===== hdl/srpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the step pulse ramp controller.
package srpc_pkg;

  localparam int CHANNELS  = 4;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W      = 2;
  localparam int PERIOD_W  = 16;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CMP_W     = 15;
  localparam int PHASE_W   = 2;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_STOP_ALL  = 3'd3,
    OP_FASTER    = 3'd4,
    OP_SLOWER    = 3'd5,
    OP_JOG_STOP  = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOFT_PERIOD       = 3'd0,
    REG_RAMP_PERIOD_STEP  = 3'd1,
    REG_PULSES_PER_STEP   = 3'd2,
    REG_FASTEST_PERIOD    = 3'd3,
    REG_SLOWEST_PERIOD    = 3'd4,
    REG_SPEED_STEP        = 3'd5
  } cfg_reg_e;

  localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd2;

  typedef struct packed {
    logic [PERIOD_W-1:0] soft_period;
    logic [PERIOD_W-1:0] ramp_period_step;
    logic [PERIOD_W-1:0] pulses_per_ramp_step;
    logic [PERIOD_W-1:0] fastest_period;
    logic [PERIOD_W-1:0] slowest_period;
    logic [PERIOD_W-1:0] speed_step;
  } cfg_t;

  localparam logic [PERIOD_W-1:0] RST_SOFT_PERIOD    = 16'd1800;
  localparam logic [PERIOD_W-1:0] RST_RAMP_STEP      = 16'd100;
  localparam logic [PERIOD_W-1:0] RST_PULSES_PER     = 16'd100;
  localparam logic [PERIOD_W-1:0] RST_FASTEST_PERIOD = 16'd150;
  localparam logic [PERIOD_W-1:0] RST_SLOWEST_PERIOD = 16'd1500;
  localparam logic [PERIOD_W-1:0] RST_SPEED_STEP     = 16'd100;
  localparam logic [PERIOD_W-1:0] RST_SPEED_TARGET   = 16'd300;
  localparam logic [PERIOD_W-1:0] RST_PERIOD         = 16'd1000;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD         = 16'd2;

  localparam logic [COUNT_W-1:0] ENDLESS = '1;

endpackage

// ===== hdl/srpc_ifs.sv =====
`timescale 1ns / 1ps
// Handshake interfaces for the command, result and register write channels.
interface srpc_in_if import srpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [CH_W-1:0]    channel;
  logic [COUNT_W-1:0] pulse_count;
  logic               ramp_allowed;
  logic               direction;

  modport source (output valid, opcode, channel, pulse_count, ramp_allowed, direction,
                  input ready);
  modport sink   (input valid, opcode, channel, pulse_count, ramp_allowed, direction,
                  output ready);
endinterface

interface srpc_out_if import srpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] reload_value;
  logic [CMP_W-1:0]    compare_value;
  logic [3:0]          channel_enables;
  logic [3:0]          direction_levels;
  logic                any_running;
  logic                ramp_active;
  logic [PHASE_W-1:0]  ramp_phase;
  logic [PERIOD_W-1:0] target_speed_period;

  modport source (output valid, reload_value, compare_value, channel_enables,
                  direction_levels, any_running, ramp_active, ramp_phase,
                  target_speed_period, input ready);
  modport sink   (input valid, reload_value, compare_value, channel_enables,
                  direction_levels, any_running, ramp_active, ramp_phase,
                  target_speed_period, output ready);
endinterface

interface srpc_cfg_if import srpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PERIOD_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/srpc_cfg_regs.sv =====
`timescale 1ns / 1ps
// Register file holding the six ramp and speed settings.
module srpc_cfg_regs import srpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  srpc_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_SOFT_PERIOD:      regs_d.soft_period          = cfg_i.data;
        REG_RAMP_PERIOD_STEP: regs_d.ramp_period_step     = cfg_i.data;
        REG_PULSES_PER_STEP:  regs_d.pulses_per_ramp_step = cfg_i.data;
        REG_FASTEST_PERIOD:   regs_d.fastest_period       = cfg_i.data;
        REG_SLOWEST_PERIOD:   regs_d.slowest_period       = cfg_i.data;
        REG_SPEED_STEP:       regs_d.speed_step           = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.soft_period          <= RST_SOFT_PERIOD;
      regs_q.ramp_period_step     <= RST_RAMP_STEP;
      regs_q.pulses_per_ramp_step <= RST_PULSES_PER;
      regs_q.fastest_period       <= RST_FASTEST_PERIOD;
      regs_q.slowest_period       <= RST_SLOWEST_PERIOD;
      regs_q.speed_step           <= RST_SPEED_STEP;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

// ===== hdl/srpc_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
module srpc_div import srpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [PERIOD_W-1:0] dividend_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  output logic                done_o,
  output logic [PERIOD_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(PERIOD_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [PERIOD_W-1:0] quo_q, quo_d;
  logic [PERIOD_W-1:0] dsr_q, dsr_d;
  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W+1:0] diff;

  assign shifted    = {rem_q, quo_q[PERIOD_W-1]};
  assign diff       = {1'b0, shifted} - {2'b00, dsr_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it always fits the low bits.
      if (!diff[PERIOD_W+1]) begin
        rem_d = diff[PERIOD_W-1:0];
        quo_d = {quo_q[PERIOD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[PERIOD_W-1:0];
        quo_d = {quo_q[PERIOD_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(PERIOD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

endmodule

// ===== hdl/four_axis_step_pulse_ramp_controller_unit.sv =====
`timescale 1ns / 1ps
// Top level of the four channel step pulse counter with trapezoidal period ramp.
//
//   Channel   Modport  Moves                                   Accepted when
//   in_i      sink     one command request (opcode + operands) valid && ready
//   out_o     source   one status result per command           valid && ready
//   cfg_i     sink     one register write (index, data)        valid && ready
//
// A command request is handled by a small sequencer around one shared 32 bit
// adder/subtractor. A tick walks the channels one per cycle and, while the ramp
// is on and a channel still runs, adds one ramp step state. A jog stop under
// the ramp walks the channels the same way. A start on an idle block that
// arms the ramp runs the 16 step divider, one multiply and one compare; other
// commands go from the execute state straight to the result state. The input
// is ready again at the edge that loads the result, so the next request can be
// taken in the cycle after that. The result sits in an output register, so a
// stalled result blocks only the completion of the next request. Reset is
// asynchronous and active low; no clearing pass is needed.
module four_axis_step_pulse_ramp_controller_unit import srpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  srpc_in_if.sink   in_i,
  srpc_out_if.source out_o,
  srpc_cfg_if.sink  cfg_i
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_TICK = 4'd2;
  localparam logic [3:0] S_RAMP = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ARM  = 4'd6;
  localparam logic [3:0] S_JOG  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
    return (p < MIN_PERIOD) ? MIN_PERIOD : p;
  endfunction

  cfg_t cfg;

  logic [3:0] state_q, state_d;

  // Latched request.
  op_e                op_q, op_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [COUNT_W-1:0] req_cnt_q, req_cnt_d;
  logic               allow_q, allow_d;
  logic               dir_q, dir_d;

  // Channel and ramp state.
  logic [COUNT_W-1:0]  tgt_q [CHANNELS];
  logic [COUNT_W-1:0]  tgt_d [CHANNELS];
  logic [COUNT_W-1:0]  pcnt_q [CHANNELS];
  logic [COUNT_W-1:0]  pcnt_d [CHANNELS];
  logic [CHANNELS-1:0] en_q, en_d;
  logic [CHANNELS-1:0] dirb_q, dirb_d;
  logic [PERIOD_W-1:0] speed_q, speed_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                ramp_on_q, ramp_on_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [PERIOD_W-1:0] rtc_q, rtc_d;
  logic [COUNT_W-1:0]  decel_q, decel_d;

  // Sequencer scratch.
  logic [CH_IDX_W-1:0] idx_q, idx_d;
  logic [CH_IDX_W-1:0] first_q, first_d;
  logic                found_q, found_d;
  logic [COUNT_W-1:0]  prod_q, prod_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [PERIOD_W-1:0] out_reload_q, out_reload_d;
  logic [CHANNELS-1:0] out_en_q, out_en_d;
  logic [CHANNELS-1:0] out_dir_q, out_dir_d;
  logic                out_run_q, out_run_d;
  logic                out_ramp_q, out_ramp_d;
  logic [PHASE_W-1:0]  out_phase_q, out_phase_d;
  logic [PERIOD_W-1:0] out_speed_q, out_speed_d;

  // Shared adder/subtractor.
  logic [COUNT_W-1:0] alu_a, alu_b, alu_res;
  logic               alu_sub;

  // Divider hookup.
  logic                div_start, div_done;
  logic [PERIOD_W-1:0] div_quo, div_dividend, div_divisor;

  logic                idle_w;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] chi;
  logic [PERIOD_W:0]   faster_lim, accel_diff, decel_sum;
  logic signed [PERIOD_W+1:0] slower_lim;
  logic [PERIOD_W-1:0] faster_val, slower_val, accel_val, decel_val, rtc_inc;

  srpc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // The decel length divides by the ramp step; a zero step counts as one.
  assign div_dividend = cfg.soft_period - speed_q;
  assign div_divisor  = (cfg.ramp_period_step == '0) ? PERIOD_W'(1) : cfg.ramp_period_step;

  srpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // The block is idle when no channel holds a target.
  always_comb begin
    idle_w = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (tgt_q[i] != '0) idle_w = 1'b0;
    end
  end

  assign ch_ok = int'(ch_q) < CHANNELS;
  assign chi   = ch_q[CH_IDX_W-1:0];

  // Speed commands step the target; faster saturates at the fastest limit, slower at the slowest.
  assign faster_lim = {1'b0, cfg.fastest_period} + {1'b0, cfg.speed_step};
  assign faster_val = ({1'b0, speed_q} > faster_lim) ? (speed_q - cfg.speed_step)
                                                      : cfg.fastest_period;
  assign slower_lim = $signed({2'b00, cfg.slowest_period}) - $signed({2'b00, cfg.speed_step});
  assign slower_val = ($signed({2'b00, speed_q}) < slower_lim) ? (speed_q + cfg.speed_step)
                                                                : cfg.slowest_period;

  // One ramp step: accelerate saturates at the speed target, decelerate at
  // the soft period.
  assign accel_diff = {1'b0, period_q} - {1'b0, cfg.ramp_period_step};
  assign accel_val  = (accel_diff[PERIOD_W] || (accel_diff[PERIOD_W-1:0] < speed_q))
                      ? speed_q : accel_diff[PERIOD_W-1:0];
  assign decel_sum  = {1'b0, period_q} + {1'b0, cfg.ramp_period_step};
  assign decel_val  = (decel_sum > {1'b0, cfg.soft_period}) ? cfg.soft_period
                                                            : decel_sum[PERIOD_W-1:0];
  assign rtc_inc    = rtc_q + 1'b1;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_TICK: begin
        alu_a = pcnt_q[idx_q];
        alu_b = COUNT_W'(1);
      end
      S_RAMP: begin
        alu_a   = tgt_q[first_q];
        alu_b   = pcnt_q[first_q];
        alu_sub = 1'b1;
      end
      S_JOG: begin
        alu_a = pcnt_q[idx_q];
        alu_b = decel_q;
      end
      default: ;
    endcase
  end

  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ch_d         = ch_q;
    req_cnt_d    = req_cnt_q;
    allow_d      = allow_q;
    dir_d        = dir_q;
    tgt_d        = tgt_q;
    pcnt_d       = pcnt_q;
    en_d         = en_q;
    dirb_d       = dirb_q;
    speed_d      = speed_q;
    period_d     = period_q;
    ramp_on_d    = ramp_on_q;
    phase_d      = phase_q;
    rtc_d        = rtc_q;
    decel_d      = decel_q;
    idx_d        = idx_q;
    first_d      = first_q;
    found_d      = found_q;
    prod_d       = prod_q;
    div_start    = 1'b0;
    out_valid_d  = out_valid_q;
    out_reload_d = out_reload_q;
    out_en_d     = out_en_q;
    out_dir_d    = out_dir_q;
    out_run_d    = out_run_q;
    out_ramp_d   = out_ramp_q;
    out_phase_d  = out_phase_q;
    out_speed_d  = out_speed_q;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d      = op_e'(in_i.opcode);
          ch_d      = in_i.channel;
          req_cnt_d = in_i.pulse_count;
          allow_d   = in_i.ramp_allowed;
          dir_d     = in_i.direction;
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_TICK: begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = S_TICK;
          end
          OP_START: begin
            if (ch_ok) begin
              // The direction level is latched even when the count is zero.
              dirb_d[chi] = dir_q;
              if (req_cnt_q == '0) begin
                tgt_d[chi]  = '0;
                pcnt_d[chi] = '0;
                en_d[chi]   = 1'b0;
                ramp_on_d   = 1'b0;
              end else begin
                tgt_d[chi]  = req_cnt_q;
                pcnt_d[chi] = '0;
                en_d[chi]   = 1'b1;
                if (idle_w) begin
                  if (allow_q && (speed_q < cfg.soft_period)) begin
                    div_start = 1'b1;
                    state_d   = S_DIV;
                  end else begin
                    ramp_on_d = 1'b0;
                    period_d  = clamp_period(speed_q);
                  end
                end
              end
            end
          end
          OP_STOP: begin
            if (ch_ok) begin
              tgt_d[chi]  = '0;
              pcnt_d[chi] = '0;
              en_d[chi]   = 1'b0;
              ramp_on_d   = 1'b0;
            end
          end
          OP_STOP_ALL: begin
            for (int i = 0; i < CHANNELS; i++) begin
              tgt_d[i]  = '0;
              pcnt_d[i] = '0;
            end
            en_d      = '0;
            ramp_on_d = 1'b0;
          end
          OP_FASTER: begin
            speed_d = faster_val;
            if (!ramp_on_q) period_d = clamp_period(faster_val);
          end
          OP_SLOWER: begin
            speed_d = slower_val;
            if (!ramp_on_q) period_d = clamp_period(slower_val);
          end
          OP_JOG_STOP: begin
            if (!ramp_on_q) begin
              for (int i = 0; i < CHANNELS; i++) begin
                tgt_d[i]  = '0;
                pcnt_d[i] = '0;
              end
              en_d = '0;
            end else begin
              idx_d   = '0;
              state_d = S_JOG;
            end
          end
          default: ;
        endcase
      end

      S_TICK: begin
        // Count one pulse on this channel and retire it at its target.
        if (tgt_q[idx_q] != '0) begin
          pcnt_d[idx_q] = alu_res;
          if (alu_res >= tgt_q[idx_q]) begin
            tgt_d[idx_q] = '0;
            en_d[idx_q]  = 1'b0;
          end else if (!found_q) begin
            found_d = 1'b1;
            first_d = idx_q;
          end
        end
        if (idx_q == CH_IDX_W'(CHANNELS - 1)) begin
          if (!ramp_on_q) begin
            state_d = S_DONE;
          end else if (!found_d) begin
            ramp_on_d = 1'b0;
            state_d   = S_DONE;
          end else begin
            state_d = S_RAMP;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_RAMP: begin
        // The adder gives the pulses left on the first running channel.
        state_d = S_DONE;
        if (rtc_inc < cfg.pulses_per_ramp_step) begin
          rtc_d = rtc_inc;
        end else begin
          rtc_d = '0;
          case (phase_q)
            PH_ACCEL: begin
              if (alu_res <= decel_q) begin
                phase_d = PH_DECEL;
              end else if (period_q > speed_q) begin
                period_d = clamp_period(accel_val);
              end else begin
                phase_d = PH_CRUISE;
              end
            end
            PH_CRUISE: begin
              if (alu_res <= decel_q) phase_d = PH_DECEL;
            end
            default: begin
              if (period_q < cfg.soft_period) period_d = clamp_period(decel_val);
            end
          endcase
        end
      end

      S_JOG: begin
        // Endless targets become the current count plus the decel length.
        if (tgt_q[idx_q] == ENDLESS) tgt_d[idx_q] = alu_res;
        if (idx_q == CH_IDX_W'(CHANNELS - 1)) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_DIV: begin
        if (div_done) state_d = S_MUL;
      end

      S_MUL: begin
        prod_d  = {{(COUNT_W-PERIOD_W){1'b0}}, div_quo} *
                  {{(COUNT_W-PERIOD_W){1'b0}}, cfg.pulses_per_ramp_step};
        state_d = S_ARM;
      end

      S_ARM: begin
        // Short moves split their pulses evenly between ramp up and down.
        if ({prod_q, 1'b0} > {1'b0, req_cnt_q}) begin
          decel_d = req_cnt_q >> 1;
        end else begin
          decel_d = prod_q;
        end
        rtc_d     = '0;
        phase_d   = PH_ACCEL;
        ramp_on_d = 1'b1;
        period_d  = clamp_period(cfg.soft_period);
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_reload_d = period_q - 1'b1;
          out_en_d     = en_q;
          out_dir_d    = dirb_q;
          out_run_d    = !idle_w;
          out_ramp_d   = ramp_on_q;
          out_phase_d  = phase_q;
          out_speed_d  = speed_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        tgt_q[i]  <= '0;
        pcnt_q[i] <= '0;
      end
      en_q        <= '0;
      dirb_q      <= '0;
      speed_q     <= RST_SPEED_TARGET;
      period_q    <= RST_PERIOD;
      ramp_on_q   <= 1'b0;
      phase_q     <= PH_ACCEL;
      rtc_q       <= '0;
      decel_q     <= '0;
      idx_q       <= '0;
      first_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tgt_q       <= tgt_d;
      pcnt_q      <= pcnt_d;
      en_q        <= en_d;
      dirb_q      <= dirb_d;
      speed_q     <= speed_d;
      period_q    <= period_d;
      ramp_on_q   <= ramp_on_d;
      phase_q     <= phase_d;
      rtc_q       <= rtc_d;
      decel_q     <= decel_d;
      idx_q       <= idx_d;
      first_q     <= first_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ch_q         <= ch_d;
    req_cnt_q    <= req_cnt_d;
    allow_q      <= allow_d;
    dir_q        <= dir_d;
    prod_q       <= prod_d;
    out_reload_q <= out_reload_d;
    out_en_q     <= out_en_d;
    out_dir_q    <= out_dir_d;
    out_run_q    <= out_run_d;
    out_ramp_q   <= out_ramp_d;
    out_phase_q  <= out_phase_d;
    out_speed_q  <= out_speed_d;
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.reload_value        = out_reload_q;
  assign out_o.compare_value       = out_reload_q[PERIOD_W-1:1];
  assign out_o.channel_enables     = out_en_q;
  assign out_o.direction_levels    = out_dir_q;
  assign out_o.any_running         = out_run_q;
  assign out_o.ramp_active         = out_ramp_q;
  assign out_o.ramp_phase          = out_phase_q;
  assign out_o.target_speed_period = out_speed_q;

endmodule

// ===== hdl/srpc_checker.sv =====
`timescale 1ns / 1ps
// Port level checks on the step pulse ramp controller, bound to its top level.
module srpc_checker import srpc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [PERIOD_W-1:0] reload_value_i,
  input logic [CMP_W-1:0]    compare_value_i
);

  // A taken request moves the sequencer out of its idle state, which drops input ready.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a request was taken");

  // A stalled result keeps its place and its value.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(reload_value_i))
    else $error("stalled result dropped or changed");

  // The compare value is half the reload value.
  a_half_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> compare_value_i == reload_value_i[PERIOD_W-1:1])
    else $error("compare value is not half the reload value");

  // The period is clamped to at least two, so the reload is never zero, and a 16 bit period keeps it below all ones.
  a_reload_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> reload_value_i != '0 && reload_value_i != '1)
    else $error("reload value outside the clamped period range");

endmodule

bind four_axis_step_pulse_ramp_controller_unit srpc_checker u_srpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .reload_value_i  (out_o.reload_value),
  .compare_value_i (out_o.compare_value)
);

// ===== sim/four_axis_step_pulse_ramp_controller_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the four channel step pulse ramp controller.
module four_axis_step_pulse_ramp_controller_unit_test;
  import srpc_pkg::*;

  // The opcode field is three bits wide, so one code is left without a meaning.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  // Cycles without any accepted request, status word or register write before
  // the run is declared hung. The slowest legal wait is a long sender gap, a long
  // result stall and a ramp-arming start.
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [PERIOD_W-1:0] reload_value;
    logic [CMP_W-1:0]    compare_value;
    logic [3:0]          channel_enables;
    logic [3:0]          direction_levels;
    logic                any_running;
    logic                ramp_active;
    logic [PHASE_W-1:0]  ramp_phase;
    logic [PERIOD_W-1:0] target_speed_period;
  } status_t;

  logic clk_i;
  logic rst_ni;

  srpc_in_if  cmd_if ();
  srpc_out_if status_if ();
  srpc_cfg_if reg_if ();

  four_axis_step_pulse_ramp_controller_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (status_if),
    .cfg_i  (reg_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow copy of the controller: register file, per channel pulse targets
  // and counts, and the shared period ramp.
  cfg_t                cfg_m;
  logic [COUNT_W-1:0]  mtr_target [CHANNELS];
  logic [COUNT_W-1:0]  mtr_count  [CHANNELS];
  logic [3:0]          en_bits;
  logic [3:0]          dir_bits;
  logic [PERIOD_W-1:0] speed_tgt;
  logic [PERIOD_W-1:0] cur_period;
  logic                ramp_on;
  logic [PHASE_W-1:0]  ramp_ph;
  logic [15:0]         ramp_ticks;
  logic [COUNT_W-1:0]  decel_len;

  // Status words still owed by the block, oldest first.
  status_t     status_expected_q [$];
  status_t     status_head;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int          ready_hold;
  // While set, neither side inserts gaps or stalls.
  bit          steady;

  task automatic reset_predictor();
    int i;
    cfg_m.soft_period          = RST_SOFT_PERIOD;
    cfg_m.ramp_period_step     = RST_RAMP_STEP;
    cfg_m.pulses_per_ramp_step = RST_PULSES_PER;
    cfg_m.fastest_period       = RST_FASTEST_PERIOD;
    cfg_m.slowest_period       = RST_SLOWEST_PERIOD;
    cfg_m.speed_step           = RST_SPEED_STEP;
    for (i = 0; i < CHANNELS; i++) begin
      mtr_target[i] = '0;
      mtr_count[i]  = '0;
    end
    en_bits    = '0;
    dir_bits   = '0;
    speed_tgt  = RST_SPEED_TARGET;
    cur_period = RST_PERIOD;
    ramp_on    = 1'b0;
    ramp_ph    = PH_ACCEL;
    ramp_ticks = '0;
    decel_len  = '0;
  endtask

  // Every period update saturates to the 16 bit range with a floor of two.
  function automatic void load_period(input int p);
    if (p < 2) p = 2;
    if (p > 65535) p = 65535;
    cur_period = p[15:0];
  endfunction

  function automatic bit no_targets();
    int i;
    bit idle;
    idle = 1'b1;
    for (i = 0; i < CHANNELS; i++)
      if (mtr_target[i] != '0) idle = 1'b0;
    return idle;
  endfunction

  function automatic void stop_channel(input int c);
    en_bits[c]    = 1'b0;
    mtr_target[c] = '0;
    mtr_count[c]  = '0;
    ramp_on       = 1'b0;
  endfunction

  // A start on an idle block either jumps straight to the target period or
  // begins the trapezoid at the soft period. The decel length is the number
  // of pulses the way back takes, capped at half the move.
  function automatic void arm_soft_ramp(input logic [COUNT_W-1:0] pulses, input logic allow);
    logic [31:0] div;
    logic [31:0] steps;
    if (!allow || speed_tgt >= cfg_m.soft_period) begin
      ramp_on = 1'b0;
      load_period(int'(speed_tgt));
      return;
    end
    div       = (cfg_m.ramp_period_step != '0) ? {16'd0, cfg_m.ramp_period_step} : 32'd1;
    steps     = ({16'd0, cfg_m.soft_period} - {16'd0, speed_tgt}) / div;
    decel_len = steps * {16'd0, cfg_m.pulses_per_ramp_step};
    if ({decel_len, 1'b0} > {1'b0, pulses}) decel_len = pulses >> 1;
    ramp_ticks = '0;
    ramp_ph    = PH_ACCEL;
    ramp_on    = 1'b1;
    load_period(int'(cfg_m.soft_period));
  endfunction

  // One pulse on every channel with a target, then one ramp step every
  // pulses_per_ramp_step pulses, steered by the pulses left on the first
  // running channel.
  function automatic void advance_pulse();
    int i;
    int a;
    bit found;
    logic [COUNT_W-1:0] left;
    left  = '0;
    found = 1'b0;
    for (i = 0; i < CHANNELS; i++) begin
      if (mtr_target[i] != '0) begin
        mtr_count[i] = mtr_count[i] + 32'd1;
        if (mtr_count[i] >= mtr_target[i]) begin
          en_bits[i]    = 1'b0;
          mtr_target[i] = '0;
        end
      end
    end
    if (!ramp_on) return;
    for (i = 0; i < CHANNELS; i++) begin
      if (!found && mtr_target[i] != '0) begin
        left  = mtr_target[i] - mtr_count[i];
        found = 1'b1;
      end
    end
    if (left == '0) begin
      ramp_on = 1'b0;
      return;
    end
    ramp_ticks = ramp_ticks + 16'd1;
    if (ramp_ticks < cfg_m.pulses_per_ramp_step) return;
    ramp_ticks = '0;
    a = int'(cur_period);
    if (ramp_ph == PH_ACCEL) begin
      if (left <= decel_len) begin
        ramp_ph = PH_DECEL;
      end else if (cur_period > speed_tgt) begin
        a = a - int'({16'd0, cfg_m.ramp_period_step});
        if (a < int'({16'd0, speed_tgt})) a = int'(speed_tgt);
        load_period(a);
      end else begin
        ramp_ph = PH_CRUISE;
      end
    end else if (ramp_ph == PH_CRUISE) begin
      if (left <= decel_len) ramp_ph = PH_DECEL;
    end else if (cur_period < cfg_m.soft_period) begin
      // Decelerate, and the unused fourth phase code behaves the same way.
      a = a + int'({16'd0, cfg_m.ramp_period_step});
      if (a > int'({16'd0, cfg_m.soft_period})) a = int'(cfg_m.soft_period);
      load_period(a);
    end
  endfunction

  function automatic status_t predict_status(input logic [2:0] op, input logic [1:0] ch,
                                             input logic [COUNT_W-1:0] pc, input logic allow,
                                             input logic dir);
    status_t st;
    logic none_running;
    logic [PERIOD_W-1:0] rl;
    int s;
    int lim;
    int stp;
    int i;
    s   = int'(speed_tgt);
    stp = int'(cfg_m.speed_step);
    case (op)
      OP_TICK: advance_pulse();
      OP_START: begin
        // The direction level is latched even when the start acts as a stop.
        dir_bits[ch] = dir;
        if (pc == '0) begin
          stop_channel(int'(ch));
        end else begin
          none_running   = no_targets();
          mtr_target[ch] = pc;
          mtr_count[ch]  = '0;
          if (none_running) arm_soft_ramp(pc, allow);
          en_bits[ch] = 1'b1;
        end
      end
      OP_STOP: stop_channel(int'(ch));
      OP_STOP_ALL: begin
        for (i = 0; i < CHANNELS; i++) stop_channel(i);
      end
      OP_FASTER: begin
        lim = int'(cfg_m.fastest_period);
        if (s > lim + stp) s = s - stp;
        else s = lim;
        speed_tgt = s[15:0];
        if (!ramp_on) load_period(int'(speed_tgt));
      end
      OP_SLOWER: begin
        lim = int'(cfg_m.slowest_period);
        if (s < lim - stp) s = s + stp;
        else s = lim;
        speed_tgt = s[15:0];
        if (!ramp_on) load_period(int'(speed_tgt));
      end
      OP_JOG_STOP: begin
        // Without a ramp a jog stop is a hard stop; with one, endless moves
        // get a finite target that leaves room for the deceleration.
        if (!ramp_on) begin
          for (i = 0; i < CHANNELS; i++) stop_channel(i);
        end else begin
          for (i = 0; i < CHANNELS; i++)
            if (mtr_target[i] == ENDLESS) mtr_target[i] = mtr_count[i] + decel_len;
        end
      end
      default: ;
    endcase
    rl                     = cur_period - 16'd1;
    st.reload_value        = rl;
    st.compare_value       = rl[15:1];
    st.channel_enables     = en_bits;
    st.direction_levels    = dir_bits;
    st.any_running         = !no_targets();
    st.ramp_active         = ramp_on;
    st.ramp_phase          = ramp_ph;
    st.target_speed_period = speed_tgt;
    return st;
  endfunction

  // Most gaps are short, a few are long, and none at all in steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly short moves that see a full trapezoid, plus endless jogs, zero
  // counts that stop a channel, and full 32 bit counts.
  function automatic logic [COUNT_W-1:0] pick_pulse_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 60);
    if (r < 80) return ENDLESS;
    if (r < 88) return '0;
    return $urandom;
  endfunction

  task automatic send_cmd(input logic [2:0] op, input logic [1:0] ch,
                          input logic [COUNT_W-1:0] pc, input logic allow, input logic dir);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_if.valid        <= 1'b1;
    cmd_if.opcode       <= op;
    cmd_if.channel      <= ch;
    cmd_if.pulse_count  <= pc;
    cmd_if.ramp_allowed <= allow;
    cmd_if.direction    <= dir;
    do @(posedge clk_i); while (!cmd_if.ready);
    status_expected_q.push_back(predict_status(op, ch, pc, allow, dir));
    items_sent++;
  endtask

  // Operand fields that the opcode does not use carry random bits.
  task automatic send_op(input logic [2:0] op);
    send_cmd(op, 2'($urandom), $urandom, 1'($urandom), 1'($urandom));
  endtask

  // Stop sending and wait until the block has returned every status word,
  // then wait on so that its sequencer is surely idle.
  task automatic wait_drained();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (status_expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [PERIOD_W-1:0] val);
    @(negedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= val;
    do @(posedge clk_i); while (!reg_if.ready);
    case (idx)
      REG_SOFT_PERIOD:      cfg_m.soft_period          = val;
      REG_RAMP_PERIOD_STEP: cfg_m.ramp_period_step     = val;
      REG_PULSES_PER_STEP:  cfg_m.pulses_per_ramp_step = val;
      REG_FASTEST_PERIOD:   cfg_m.fastest_period       = val;
      REG_SLOWEST_PERIOD:   cfg_m.slowest_period       = val;
      REG_SPEED_STEP:       cfg_m.speed_step           = val;
      default: ;
    endcase
    @(negedge clk_i);
    reg_if.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Every status word that leaves the block is compared with the oldest
  // outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && status_if.valid && status_if.ready) begin
      if (status_expected_q.size() == 0) begin
        $display("%0t ns: status word with none outstanding", $time);
        mismatch_count++;
      end else begin
        status_head = status_expected_q.pop_front();
        check_field("reload_value", 32'(status_head.reload_value),
                    32'(status_if.reload_value));
        check_field("compare_value", 32'(status_head.compare_value),
                    32'(status_if.compare_value));
        check_field("channel_enables", 32'(status_head.channel_enables),
                    32'(status_if.channel_enables));
        check_field("direction_levels", 32'(status_head.direction_levels),
                    32'(status_if.direction_levels));
        check_field("any_running", 32'(status_head.any_running),
                    32'(status_if.any_running));
        check_field("ramp_active", 32'(status_head.ramp_active),
                    32'(status_if.ramp_active));
        check_field("ramp_phase", 32'(status_head.ramp_phase),
                    32'(status_if.ramp_phase));
        check_field("target_speed_period", 32'(status_head.target_speed_period),
                    32'(status_if.target_speed_period));
      end
    end
  end

  // The result side stalls for random stretches of its own.
  initial begin
    status_if.ready = 1'b0;
    ready_hold      = 0;
    forever begin
      @(negedge clk_i);
      if (ready_hold > 0) begin
        status_if.ready <= 1'b0;
        ready_hold = ready_hold - 1;
      end else begin
        status_if.ready <= 1'b1;
        ready_hold = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (status_if.valid && status_if.ready) ||
        (reg_if.valid && reg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset register values: each opcode at least once, hard and soft stops, endless
  // jog, zero-count start that still latches direction, and count extremes.
  task automatic test_status_and_commands();
    send_op(OP_UNUSED);
    send_op(OP_FASTER);
    send_cmd(OP_START, 2'd0, 32'd10, 1'b1, 1'b1);
    send_cmd(OP_START, 2'd3, ENDLESS, 1'b0, 1'b0);
    send_op(OP_TICK);
    send_op(OP_JOG_STOP);
    send_cmd(OP_STOP, 2'd0, '0, 1'b0, 1'b0);
    send_op(OP_SLOWER);
    send_op(OP_JOG_STOP);
    send_cmd(OP_START, 2'd2, 32'd0, 1'b1, 1'b1);
    send_cmd(OP_START, 2'd1, 32'd1, 1'b0, 1'b1);
    send_op(OP_TICK);
    send_cmd(OP_START, 2'd2, 32'hFFFF_FFFE, 1'b1, 1'b0);
    send_op(OP_STOP_ALL);
  endtask

  // All registers at their largest and smallest values, saturating speed
  // commands, a slower command whose step reaches the slowest period, and
  // the zero ramp step and zero pulses-per-step corner cases.
  task automatic test_register_extremes();
    wait_drained();
    write_reg(REG_SOFT_PERIOD, 16'hFFFF);
    write_reg(REG_RAMP_PERIOD_STEP, 16'hFFFF);
    write_reg(REG_PULSES_PER_STEP, 16'hFFFF);
    write_reg(REG_FASTEST_PERIOD, 16'hFFFF);
    write_reg(REG_SLOWEST_PERIOD, 16'hFFFF);
    write_reg(REG_SPEED_STEP, 16'hFFFF);
    send_op(OP_FASTER);
    send_op(OP_SLOWER);
    send_cmd(OP_START, 2'd0, 32'd1000, 1'b1, 1'b1);
    send_op(OP_STOP_ALL);
    wait_drained();
    write_reg(REG_SOFT_PERIOD, 16'd2);
    write_reg(REG_RAMP_PERIOD_STEP, 16'd1);
    write_reg(REG_PULSES_PER_STEP, 16'd1);
    write_reg(REG_FASTEST_PERIOD, 16'd2);
    write_reg(REG_SLOWEST_PERIOD, 16'd2);
    write_reg(REG_SPEED_STEP, 16'd1);
    send_op(OP_FASTER);
    send_op(OP_SLOWER);
    wait_drained();
    write_reg(REG_SOFT_PERIOD, 16'd40);
    write_reg(REG_RAMP_PERIOD_STEP, 16'd0);
    write_reg(REG_PULSES_PER_STEP, 16'd2);
    send_cmd(OP_START, 2'd2, 32'd20, 1'b1, 1'b1);
    send_op(OP_TICK);
    send_op(OP_TICK);
    send_op(OP_STOP_ALL);
    wait_drained();
    write_reg(REG_RAMP_PERIOD_STEP, 16'd5);
    write_reg(REG_PULSES_PER_STEP, 16'd0);
    send_cmd(OP_START, 2'd0, 32'd8, 1'b1, 1'b0);
    send_op(OP_TICK);
    send_op(OP_TICK);
    send_op(OP_STOP_ALL);
  endtask

  // Well-formed motion profiles: one or more starts followed by a run of
  // ticks, with speed commands, jog stops, stops and late starts mixed in.
  // The registers are retuned every so often; most settings are small so
  // that a few dozen ticks cover accelerate, cruise and decelerate.
  task automatic test_motion_profiles(input int n_items);
    int stop_at;
    int retune_at;
    int k;
    int r;
    int n_ticks;
    logic [PERIOD_W-1:0] sp, rs, pp, fp, lp, ss;
    stop_at   = items_sent + n_items;
    retune_at = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= retune_at) begin
        wait_drained();
        if ($urandom_range(0, 4) == 0) begin
          sp = 16'hFFFF;
          rs = 16'($urandom_range(1, 65535));
          pp = 16'($urandom_range(1, 3));
          fp = 16'd2;
          lp = 16'hFFFF;
          ss = 16'($urandom_range(1, 65535));
        end else begin
          sp = 16'($urandom_range(10, 60));
          rs = 16'($urandom_range(1, 8));
          pp = 16'($urandom_range(1, 4));
          fp = 16'($urandom_range(2, 9));
          lp = 16'($urandom_range(20, 80));
          ss = 16'($urandom_range(1, 20));
        end
        write_reg(REG_SOFT_PERIOD, sp);
        write_reg(REG_RAMP_PERIOD_STEP, rs);
        write_reg(REG_PULSES_PER_STEP, pp);
        write_reg(REG_FASTEST_PERIOD, fp);
        write_reg(REG_SLOWEST_PERIOD, lp);
        // A full-size speed step pulls the target down to the fastest period
        // in one command, so that the next start can ramp.
        write_reg(REG_SPEED_STEP, 16'hFFFF);
        send_op(OP_FASTER);
        wait_drained();
        write_reg(REG_SPEED_STEP, ss);
        retune_at = items_sent + 140;
      end
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0)
        send_op(($urandom_range(0, 1) != 0) ? OP_FASTER : OP_SLOWER);
      for (k = $urandom_range(1, 4); k > 0; k--)
        send_cmd(OP_START, 2'($urandom_range(0, 3)), pick_pulse_count(),
                 $urandom_range(0, 9) != 0, 1'($urandom));
      n_ticks = $urandom_range(4, 90);
      for (k = 0; k < n_ticks; k++) begin
        r = $urandom_range(0, 99);
        if (r < 86) send_op(OP_TICK);
        else if (r < 90) send_op(($urandom_range(0, 1) != 0) ? OP_FASTER : OP_SLOWER);
        else if (r < 94) send_op(OP_JOG_STOP);
        else if (r < 96) send_op(OP_STOP);
        else if (r < 98) send_cmd(OP_START, 2'($urandom), pick_pulse_count(),
                                  1'($urandom), 1'($urandom));
        else wait_drained();
      end
      if ($urandom_range(0, 1) == 0) send_op(OP_STOP_ALL);
    end
    steady = 1'b0;
  endtask

  // Unstructured requests: any defined opcode with any operands.
  task automatic test_random_commands(input int n_items);
    repeat (n_items)
      send_cmd(3'($urandom_range(0, 6)), 2'($urandom),
               ($urandom_range(0, 1) != 0) ? pick_pulse_count() : 32'($urandom),
               1'($urandom), 1'($urandom));
  endtask

  initial begin
    cmd_if.valid        = 1'b0;
    cmd_if.opcode       = OP_TICK;
    cmd_if.channel      = '0;
    cmd_if.pulse_count  = '0;
    cmd_if.ramp_allowed = 1'b0;
    cmd_if.direction    = 1'b0;
    reg_if.valid        = 1'b0;
    reg_if.index        = REG_SOFT_PERIOD;
    reg_if.data         = '0;
    rst_ni              = 1'b0;
    steady              = 1'b0;
    items_sent          = 0;
    reset_predictor();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_status_and_commands();
    test_register_extremes();
    test_motion_profiles(1050);
    test_random_commands(300);

    // Every request has been accepted; collect the last status words and
    // give the block a little time to show any stray output.
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== four_axis_step_pulse_ramp_controller_unit.f =====
hdl/srpc_pkg.sv
hdl/srpc_ifs.sv
hdl/srpc_cfg_regs.sv
hdl/srpc_div.sv
hdl/four_axis_step_pulse_ramp_controller_unit.sv
hdl/srpc_checker.sv
sim/four_axis_step_pulse_ramp_controller_unit_test.sv
